[sv/s7b_pkg.sv]
package s7b_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 4;
  localparam int TAPS       = 7;
  localparam int HALF_TAPS  = TAPS / 2;
  localparam int RING_ROWS  = 2 * HALF_TAPS;
  localparam int LANE_W     = $clog2(RING_ROWS);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 13;
  localparam int POS_W      = $clog2(HALF_TAPS + 1);
  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int CHANNELS   = PIX_W / CH_W;
  localparam int WT_W       = 16;
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;
  localparam int DATA_W     = 32;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(64);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(64);
  localparam logic [WT_W-1:0]     OUTER_RESET  = WT_W'(0);
  localparam logic [WT_W-1:0]     FAR_RESET    = WT_W'(10486);
  localparam logic [WT_W-1:0]     NEAR_RESET   = WT_W'(20972);
  localparam logic [WT_W-1:0]     CENTER_RESET = WT_W'(0);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_WEIGHT_OUTER,
    REG_WEIGHT_FAR,
    REG_WEIGHT_NEAR,
    REG_WEIGHT_CENTER
  } reg_idx_t;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel_in;
  } pix_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } res_beat_t;

  typedef logic [TAPS-1:0][PIX_W-1:0]      tap_vec_t;
  typedef logic [TAPS-1:0][WT_W-1:0]       weights_t;
  typedef logic [RING_ROWS-1:0][PIX_W-1:0] ring_word_t;

  typedef struct packed {
    logic              emit;
    logic              wr;
    logic              last;
    logic [LANE_W-1:0] ph;
    logic [COL_W-1:0]  col;
    logic [TAPS-1:0]   vmask;
  } ctl_t;

  function automatic logic [PIX_W-1:0] term32(input logic [PIX_W-1:0] p,
                                              input logic [WT_W-1:0] wt);
    logic [PIX_W-1:0]     r;
    logic [CH_W+WT_W-1:0] prod;
    r = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      prod = (CH_W + WT_W)'(p[CH_W*ch +: CH_W]) * (CH_W + WT_W)'(wt);
      r[CH_W*ch +: CH_W] = prod[CH_W+WT_W-1:WT_W];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] add32(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    r = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      r[CH_W*ch +: CH_W] = a[CH_W*ch +: CH_W] + b[CH_W*ch +: CH_W];
    end
    return r;
  endfunction

  function automatic logic [LANE_W-1:0] ring_lane(input logic [LANE_W-1:0] ph,
                                                  input logic [LANE_W-1:0] k);
    logic [LANE_W:0] s;
    s = {1'b0, ph} + {1'b0, k};
    if (s >= (LANE_W + 1)'(RING_ROWS)) begin
      s = s - (LANE_W + 1)'(RING_ROWS);
    end
    return s[LANE_W-1:0];
  endfunction

endpackage

[sv/s7b_row_store.sv]
module s7b_row_store (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [s7b_pkg::COL_W-1:0]    rd_addr,
  output s7b_pkg::ring_word_t          rd_data,
  input  logic                         wr_en,
  input  logic [s7b_pkg::COL_W-1:0]    wr_addr,
  input  s7b_pkg::ring_word_t          wr_data
);

  s7b_pkg::ring_word_t mem [s7b_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/s7b_scan.sv]
module s7b_scan (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [s7b_pkg::WIDTH_W-1:0]    width,
  input  logic [s7b_pkg::HEIGHT_W-1:0]   height,
  output logic [s7b_pkg::COL_W-1:0]      col,
  output logic                           restart,
  output s7b_pkg::ctl_t                  ctl1
);

  localparam int XR_W = s7b_pkg::ROW_W + 1;

  logic [s7b_pkg::POS_W-1:0]  pos;
  logic [s7b_pkg::ROW_W-1:0]  row;
  logic [s7b_pkg::LANE_W-1:0] ph;

  logic              live;
  logic              col_end;
  logic              row_done;
  logic [XR_W-1:0]   rowx;
  logic [XR_W-1:0]   hx;
  s7b_pkg::ctl_t     ctl_next;

  always_comb begin
    live     = (pos == s7b_pkg::POS_W'(s7b_pkg::HALF_TAPS));
    rowx     = {1'b0, row};
    hx       = XR_W'(height);
    col_end  = ({1'b0, col} + s7b_pkg::WIDTH_W'(1)) >= width;
    row_done = rowx >= hx + XR_W'(s7b_pkg::HALF_TAPS - 1);
    restart  = load && live && col_end && row_done;

    ctl_next.col  = col;
    ctl_next.ph   = ph;
    ctl_next.wr   = live && (rowx < hx);
    ctl_next.emit = live && (rowx >= XR_W'(s7b_pkg::HALF_TAPS)) &&
                    (rowx < hx + XR_W'(s7b_pkg::HALF_TAPS));
    ctl_next.last = live && col_end &&
                    (rowx == hx + XR_W'(s7b_pkg::HALF_TAPS - 1));
    for (int k = 0; k < s7b_pkg::TAPS; k++) begin
      ctl_next.vmask[k] = live &&
                          (rowx + XR_W'(k) >= XR_W'(s7b_pkg::RING_ROWS)) &&
                          (rowx + XR_W'(k) < hx + XR_W'(s7b_pkg::RING_ROWS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      col <= '0;
      row <= '0;
      ph  <= '0;
    end else if (load) begin
      if (!live) begin
        pos <= pos + s7b_pkg::POS_W'(1);
      end else if (col_end) begin
        col <= '0;
        if (row_done) begin
          row <= '0;
          ph  <= '0;
          pos <= '0;
        end else begin
          row <= row + s7b_pkg::ROW_W'(1);
          ph  <= (ph == s7b_pkg::LANE_W'(s7b_pkg::RING_ROWS - 1)) ?
                 '0 : ph + s7b_pkg::LANE_W'(1);
        end
      end else begin
        col <= col + s7b_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl1 <= ctl_next;
    end
  end

  a_ring_phase_aligned: assert property (@(posedge clk) disable iff (rst)
    (row == '0) |-> (ph == '0))
    else $error("ring phase out of step with row");

  a_priming_at_origin: assert property (@(posedge clk) disable iff (rst)
    !live |-> (row == '0 && col == '0))
    else $error("window priming away from frame origin");

endmodule

[sv/s7b_hpass.sv]
module s7b_hpass (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          clear,
  input  logic [s7b_pkg::PIX_W-1:0]     pixel,
  input  logic                          adv,
  input  logic [s7b_pkg::COL_W-1:0]     col,
  input  logic [s7b_pkg::WIDTH_W-1:0]   width,
  input  s7b_pkg::weights_t             weights,
  output logic [s7b_pkg::PIX_W-1:0]     hq
);

  localparam int CX_W = s7b_pkg::WIDTH_W + 1;

  s7b_pkg::tap_vec_t window;
  s7b_pkg::tap_vec_t shifted;
  s7b_pkg::tap_vec_t win1;
  s7b_pkg::tap_vec_t terms2;
  logic [s7b_pkg::TAPS-1:0] hmask;
  logic [CX_W-1:0]          cx;

  always_comb begin
    for (int k = 0; k < s7b_pkg::TAPS - 1; k++) begin
      shifted[k] = window[k+1];
    end
    shifted[s7b_pkg::TAPS-1] = pixel;
  end

  always_comb begin
    cx = '0;
    for (int k = 0; k < s7b_pkg::TAPS; k++) begin
      cx = CX_W'(col) + CX_W'(k);
      hmask[k] = (cx >= CX_W'(s7b_pkg::HALF_TAPS)) &&
                 (cx < CX_W'(width) + CX_W'(s7b_pkg::HALF_TAPS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (load) begin
      window <= clear ? '0 : shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      win1 <= shifted;
    end
    if (adv) begin
      for (int k = 0; k < s7b_pkg::TAPS; k++) begin
        terms2[k] <= hmask[k] ? s7b_pkg::term32(win1[k], weights[k]) : '0;
      end
    end
  end

  always_comb begin
    hq = '0;
    for (int k = 0; k < s7b_pkg::TAPS; k++) begin
      hq = s7b_pkg::add32(hq, terms2[k]);
    end
  end

endmodule

[sv/s7b_vpass.sv]
module s7b_vpass (
  input  logic                       clk,
  input  logic                       adv2,
  input  logic                       adv3,
  input  s7b_pkg::ring_word_t        word_in,
  input  s7b_pkg::ctl_t              ctl2,
  input  s7b_pkg::ctl_t              ctl3,
  input  s7b_pkg::weights_t          weights,
  input  logic [s7b_pkg::PIX_W-1:0]  hq,
  output s7b_pkg::ring_word_t        word2,
  output logic [s7b_pkg::PIX_W-1:0]  pix
);

  localparam int NEW = s7b_pkg::TAPS - 1;

  logic [NEW-1:0][s7b_pkg::PIX_W-1:0] terms_next;
  logic [NEW-1:0][s7b_pkg::PIX_W-1:0] terms3;
  logic [s7b_pkg::PIX_W-1:0]          hq3;
  logic [s7b_pkg::LANE_W-1:0]         lane;

  always_comb begin
    lane = '0;
    for (int k = 0; k < NEW; k++) begin
      lane = s7b_pkg::ring_lane(ctl2.ph, s7b_pkg::LANE_W'(k));
      terms_next[k] = ctl2.vmask[k] ?
                      s7b_pkg::term32(word2[lane], weights[k]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      word2 <= word_in;
    end
    if (adv3) begin
      terms3 <= terms_next;
      hq3    <= hq;
    end
  end

  always_comb begin
    pix = ctl3.vmask[NEW] ? s7b_pkg::term32(hq3, weights[NEW]) : '0;
    for (int k = 0; k < NEW; k++) begin
      pix = s7b_pkg::add32(pix, terms3[k]);
    end
  end

endmodule

[sv/separable_seven_tap_rgba_blur_core.sv]
// Each result goes through S1, S2, S3 and the output register after its completing item;
// each result trails its pixel by 3*frame_width+3 items (send that many flush beats).
// Throughput: one beat per cycle while the result side is not stalled, set by one
// read-modify-write of the column's ring word in the row store per beat. The output
// register holds a result while res_ready is low, and that stall can reach pix_ready.
// Reset: counters, tap window, pipeline valids and config registers return to defaults; the row store is not cleared.
module separable_seven_tap_rgba_blur_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  output logic                              pix_ready,
  input  s7b_pkg::pix_beat_t                pix_data,
  output logic                              res_valid,
  input  logic                              res_ready,
  output s7b_pkg::res_beat_t                res_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [s7b_pkg::ADDR_W-1:0]        paddr,
  input  logic [s7b_pkg::DATA_W-1:0]        pwdata,
  output logic [s7b_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  logic [s7b_pkg::WIDTH_W-1:0]  frame_width;
  logic [s7b_pkg::HEIGHT_W-1:0] frame_height;
  logic [s7b_pkg::WT_W-1:0]     weight_outer;
  logic [s7b_pkg::WT_W-1:0]     weight_far;
  logic [s7b_pkg::WT_W-1:0]     weight_near;
  logic [s7b_pkg::WT_W-1:0]     weight_center;
  s7b_pkg::weights_t            weights;

  logic [s7b_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          reg_wr;
  logic [s7b_pkg::WIDTH_W-1:0]   wdata_w;
  logic [s7b_pkg::HEIGHT_W-1:0]  wdata_h;

  logic v1, v2, v3;
  logic move1, move2, move3;
  logic rdy2, rdy3;
  logic out_free;
  logic acc;

  s7b_pkg::ctl_t ctl1, ctl2, ctl3;
  logic [s7b_pkg::COL_W-1:0] rd_col;
  logic                      restart;
  logic [s7b_pkg::PIX_W-1:0] pixel_val;
  logic [s7b_pkg::PIX_W-1:0] hq;
  logic [s7b_pkg::PIX_W-1:0] vpix;

  s7b_pkg::ring_word_t rd_word;
  s7b_pkg::ring_word_t word2;
  s7b_pkg::ring_word_t wr_word;
  logic                mem_wr_en;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[s7b_pkg::ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;
  assign wdata_w = pwdata[s7b_pkg::WIDTH_W-1:0];
  assign wdata_h = pwdata[s7b_pkg::HEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= s7b_pkg::WIDTH_RESET;
      frame_height  <= s7b_pkg::HEIGHT_RESET;
      weight_outer  <= s7b_pkg::OUTER_RESET;
      weight_far    <= s7b_pkg::FAR_RESET;
      weight_near   <= s7b_pkg::NEAR_RESET;
      weight_center <= s7b_pkg::CENTER_RESET;
    end else if (reg_wr) begin
      case (reg_idx)
        s7b_pkg::REG_FRAME_WIDTH: begin
          if (wdata_w < s7b_pkg::WIDTH_W'(s7b_pkg::MIN_DIM)) begin
            frame_width <= s7b_pkg::WIDTH_W'(s7b_pkg::MIN_DIM);
          end else if (wdata_w > s7b_pkg::WIDTH_W'(s7b_pkg::MAX_WIDTH)) begin
            frame_width <= s7b_pkg::WIDTH_W'(s7b_pkg::MAX_WIDTH);
          end else begin
            frame_width <= wdata_w;
          end
        end
        s7b_pkg::REG_FRAME_HEIGHT: begin
          if (wdata_h < s7b_pkg::HEIGHT_W'(s7b_pkg::MIN_DIM)) begin
            frame_height <= s7b_pkg::HEIGHT_W'(s7b_pkg::MIN_DIM);
          end else if (wdata_h > s7b_pkg::HEIGHT_W'(s7b_pkg::MAX_HEIGHT)) begin
            frame_height <= s7b_pkg::HEIGHT_W'(s7b_pkg::MAX_HEIGHT);
          end else begin
            frame_height <= wdata_h;
          end
        end
        s7b_pkg::REG_WEIGHT_OUTER:  weight_outer  <= pwdata[s7b_pkg::WT_W-1:0];
        s7b_pkg::REG_WEIGHT_FAR:    weight_far    <= pwdata[s7b_pkg::WT_W-1:0];
        s7b_pkg::REG_WEIGHT_NEAR:   weight_near   <= pwdata[s7b_pkg::WT_W-1:0];
        s7b_pkg::REG_WEIGHT_CENTER: weight_center <= pwdata[s7b_pkg::WT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      s7b_pkg::REG_FRAME_WIDTH:   prdata = s7b_pkg::DATA_W'(frame_width);
      s7b_pkg::REG_FRAME_HEIGHT:  prdata = s7b_pkg::DATA_W'(frame_height);
      s7b_pkg::REG_WEIGHT_OUTER:  prdata = s7b_pkg::DATA_W'(weight_outer);
      s7b_pkg::REG_WEIGHT_FAR:    prdata = s7b_pkg::DATA_W'(weight_far);
      s7b_pkg::REG_WEIGHT_NEAR:   prdata = s7b_pkg::DATA_W'(weight_near);
      s7b_pkg::REG_WEIGHT_CENTER: prdata = s7b_pkg::DATA_W'(weight_center);
      default:                    prdata = '0;
    endcase
  end

  // symmetric kernel
  always_comb begin
    weights[0] = weight_outer;
    weights[1] = weight_far;
    weights[2] = weight_near;
    weights[3] = weight_center;
    weights[4] = weight_near;
    weights[5] = weight_far;
    weights[6] = weight_outer;
  end

  // pipeline flow: S1 (read issued) -> S2 (row pass sum, write back) -> S3 -> output
  always_comb begin
    out_free  = !res_valid || res_ready;
    move3     = v3 && (!ctl3.emit || out_free);
    rdy3      = !v3 || move3;
    move2     = v2 && rdy3;
    rdy2      = !v2 || rdy3;
    move1     = v1 && rdy2;
    pix_ready = !v1 || rdy2;
    acc       = pix_valid && pix_ready;
    pixel_val = pix_data.req_type ? '0 : pix_data.pixel_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1        <= acc || (v1 && !move1);
      v2        <= move1 || (v2 && !move2);
      v3        <= move2 || (v3 && !move3);
      res_valid <= (move3 && ctl3.emit) || (res_valid && !res_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      ctl2 <= ctl1;
    end
    if (move2) begin
      ctl3 <= ctl2;
    end
    if (move3 && ctl3.emit) begin
      res_data.pixel_out <= vpix;
      res_data.frame_end <= ctl3.last;
    end
  end

  // write back: replace this row's lane in the column word
  always_comb begin
    wr_word            = word2;
    wr_word[ctl2.ph]   = hq;
    mem_wr_en          = move2 && ctl2.wr;
  end

  s7b_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .load    (acc),
    .width   (frame_width),
    .height  (frame_height),
    .col     (rd_col),
    .restart (restart),
    .ctl1    (ctl1)
  );

  s7b_row_store u_row_store (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (rd_col),
    .rd_data (rd_word),
    .wr_en   (mem_wr_en),
    .wr_addr (ctl2.col),
    .wr_data (wr_word)
  );

  s7b_hpass u_hpass (
    .clk     (clk),
    .rst     (rst),
    .load    (acc),
    .clear   (restart),
    .pixel   (pixel_val),
    .adv     (move1),
    .col     (ctl1.col),
    .width   (frame_width),
    .weights (weights),
    .hq      (hq)
  );

  s7b_vpass u_vpass (
    .clk     (clk),
    .adv2    (move1),
    .adv3    (move2),
    .word_in (rd_word),
    .ctl2    (ctl2),
    .ctl3    (ctl3),
    .weights (weights),
    .hq      (hq),
    .word2   (word2),
    .pix     (vpix)
  );

  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem_wr_en && acc) |-> (ctl2.col != rd_col))
    else $error("row store read and write hit the same column");

  a_emit_loads_output: assert property (@(posedge clk) disable iff (rst)
    (move3 && ctl3.emit) |=> res_valid)
    else $error("result beat dropped at output register");

  a_last_is_emitted: assert property (@(posedge clk) disable iff (rst)
    (v3 && ctl3.last) |-> ctl3.emit)
    else $error("frame end flagged on a position with no result");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int GAP_LIMIT    = 10;
  localparam int DRAIN_CYCLES = 16;
  localparam int RING_SIZE    = s7b_pkg::RING_ROWS * s7b_pkg::MAX_WIDTH;
  localparam int PRINT_CAP    = 200;
  localparam int RANDOM_ITEMS = 400;

  logic                       clk;
  logic                       rst       = 1'b1;
  logic                       pix_valid = 1'b0;
  logic                       pix_ready;
  s7b_pkg::pix_beat_t         pix_data  = '0;
  logic                       res_valid;
  logic                       res_ready = 1'b0;
  s7b_pkg::res_beat_t         res_data;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [s7b_pkg::ADDR_W-1:0] paddr     = '0;
  logic [s7b_pkg::DATA_W-1:0] pwdata    = '0;
  logic [s7b_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  separable_seven_tap_rgba_blur_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // blur predictor state
  int                       cfg_width  = 64;
  int                       cfg_height = 64;
  logic [s7b_pkg::WT_W-1:0] wt_outer   = s7b_pkg::OUTER_RESET;
  logic [s7b_pkg::WT_W-1:0] wt_far     = s7b_pkg::FAR_RESET;
  logic [s7b_pkg::WT_W-1:0] wt_near    = s7b_pkg::NEAR_RESET;
  logic [s7b_pkg::WT_W-1:0] wt_center  = s7b_pkg::CENTER_RESET;

  logic [s7b_pkg::PIX_W-1:0] hrow_ring [RING_SIZE];
  logic [s7b_pkg::PIX_W-1:0] tap_win [s7b_pkg::TAPS];
  int                        col_cnt;
  int                        row_cnt;
  int                        warm_cnt;

  s7b_pkg::pix_beat_t pix_q[$];
  s7b_pkg::res_beat_t blurred_q[$];

  int   errors    = 0;
  int   gap_max   = GAP_LIMIT;
  int   pix_gap   = 0;
  int   res_stall = 0;
  logic pix_fired = 1'b0;
  logic res_fired = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("mismatch @%0t: %s", $time, msg);
    end
  endtask

  function automatic logic [s7b_pkg::WT_W-1:0] tap_wt(input int k);
    case (k)
      0, 6: return wt_outer;
      1, 5: return wt_far;
      2, 4: return wt_near;
      default: return wt_center;
    endcase
  endfunction

  // per-channel wrap-around accumulate of (p * w) >> 16
  function automatic logic [s7b_pkg::PIX_W-1:0] mac_rgba(
      input logic [s7b_pkg::PIX_W-1:0] acc,
      input logic [s7b_pkg::PIX_W-1:0] pix,
      input logic [s7b_pkg::WT_W-1:0]  wt);
    logic [s7b_pkg::PIX_W-1:0] sum;
    logic [23:0]               prod;
    sum = '0;
    for (int ch = 0; ch < 4; ch++) begin
      prod = 24'(pix[8*ch +: 8]) * 24'(wt);
      sum[8*ch +: 8] = acc[8*ch +: 8] + prod[23:16];
    end
    return sum;
  endfunction

  task automatic blur_predict(input s7b_pkg::pix_beat_t b);
    logic [s7b_pkg::PIX_W-1:0] hsum;
    logic [s7b_pkg::PIX_W-1:0] vsum;
    logic [s7b_pkg::PIX_W-1:0] pix;
    s7b_pkg::res_beat_t        e;
    int                        col;
    int                        row;
    int                        r;
    int                        c;
    int                        rr;
    hsum = '0;
    for (int k = 0; k < s7b_pkg::TAPS - 1; k++) begin
      tap_win[k] = tap_win[k+1];
    end
    tap_win[s7b_pkg::TAPS-1] = b.req_type ? '0 : b.pixel_in;
    if (warm_cnt < s7b_pkg::HALF_TAPS) begin
      warm_cnt++;
      return;
    end
    col = col_cnt % s7b_pkg::MAX_WIDTH;
    row = row_cnt;
    if (row < cfg_height) begin
      for (int k = 0; k < s7b_pkg::TAPS; k++) begin
        c = col + k - s7b_pkg::HALF_TAPS;
        if (c >= 0 && c < cfg_width) begin
          hsum = mac_rgba(hsum, tap_win[k], tap_wt(k));
        end
      end
    end
    if (row >= s7b_pkg::HALF_TAPS && row - s7b_pkg::HALF_TAPS < cfg_height) begin
      r = row - s7b_pkg::HALF_TAPS;
      vsum = '0;
      for (int k = 0; k < s7b_pkg::TAPS; k++) begin
        rr = r + k - s7b_pkg::HALF_TAPS;
        if (rr >= 0 && rr < cfg_height) begin
          if (k == s7b_pkg::TAPS - 1) begin
            pix = hsum;
          end else begin
            pix = hrow_ring[(((row + k) % s7b_pkg::RING_ROWS) * s7b_pkg::MAX_WIDTH + col)
                            % RING_SIZE];
          end
          vsum = mac_rgba(vsum, pix, tap_wt(k));
        end
      end
      e.pixel_out = vsum;
      e.frame_end = (r + 1 == cfg_height) && (col + 1 >= cfg_width);
      blurred_q.push_back(e);
    end
    if (row < cfg_height) begin
      hrow_ring[((row % s7b_pkg::RING_ROWS) * s7b_pkg::MAX_WIDTH + col) % RING_SIZE] = hsum;
    end
    if (col + 1 >= cfg_width) begin
      col_cnt = 0;
      if (row >= cfg_height + s7b_pkg::HALF_TAPS - 1) begin
        row_cnt  = 0;
        warm_cnt = 0;
        for (int k = 0; k < s7b_pkg::TAPS; k++) begin
          tap_win[k] = '0;
        end
      end else begin
        row_cnt = row + 1;
      end
    end else begin
      col_cnt = col + 1;
    end
  endtask

  // monitor: accepted beats on both channels
  always @(posedge clk) begin
    s7b_pkg::res_beat_t want;
    if (rst) begin
      pix_fired <= 1'b0;
      res_fired <= 1'b0;
    end else begin
      pix_fired <= pix_valid && pix_ready;
      res_fired <= res_valid && res_ready;
      if (pix_valid && pix_ready) begin
        blur_predict(pix_data);
      end
      if (res_valid && res_ready) begin
        if (blurred_q.size() == 0) begin
          report_mismatch($sformatf("result %h with none expected", res_data));
        end else begin
          want = blurred_q.pop_front();
          if (res_data.pixel_out !== want.pixel_out) begin
            report_mismatch($sformatf("pixel_out %h, want %h",
                                      res_data.pixel_out, want.pixel_out));
          end
          if (res_data.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("frame_end %b, want %b",
                                      res_data.frame_end, want.frame_end));
          end
        end
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    int gap;
    if (!rst) begin
      gap = pix_gap;
      if (pix_fired) begin
        gap = $urandom_range(0, gap_max);
      end
      if (pix_valid && !pix_fired) begin
        gap = gap;
      end else if (gap > 0) begin
        pix_valid <= 1'b0;
        gap--;
      end else if (pix_q.size() > 0) begin
        pix_data  <= pix_q.pop_front();
        pix_valid <= 1'b1;
      end else begin
        pix_valid <= 1'b0;
      end
      pix_gap = gap;
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    int stall;
    if (!rst) begin
      stall = res_stall;
      if (res_fired) begin
        stall = $urandom_range(0, gap_max);
      end
      if (stall > 0) begin
        res_ready <= 1'b0;
        stall--;
      end else begin
        res_ready <= 1'b1;
      end
      res_stall = stall;
    end
  end

  task automatic reg_write(input s7b_pkg::reg_idx_t idx,
                           input logic [s7b_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= s7b_pkg::ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(input s7b_pkg::reg_idx_t idx,
                           input logic [s7b_pkg::DATA_W-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= s7b_pkg::ADDR_W'(4 * int'(idx));
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      report_mismatch($sformatf("%s reads %h, want %h", idx.name(), prdata, want));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int clamp_dim(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic set_reg(input s7b_pkg::reg_idx_t idx,
                         input logic [s7b_pkg::DATA_W-1:0] raw);
    logic [s7b_pkg::DATA_W-1:0] held;
    reg_write(idx, raw);
    case (idx)
      s7b_pkg::REG_FRAME_WIDTH: begin
        cfg_width = clamp_dim(int'(raw[s7b_pkg::WIDTH_W-1:0]), s7b_pkg::MIN_DIM,
                              s7b_pkg::MAX_WIDTH);
        held = s7b_pkg::DATA_W'(cfg_width);
      end
      s7b_pkg::REG_FRAME_HEIGHT: begin
        cfg_height = clamp_dim(int'(raw[s7b_pkg::HEIGHT_W-1:0]), s7b_pkg::MIN_DIM,
                               s7b_pkg::MAX_HEIGHT);
        held = s7b_pkg::DATA_W'(cfg_height);
      end
      s7b_pkg::REG_WEIGHT_OUTER: begin
        wt_outer = raw[s7b_pkg::WT_W-1:0];
        held = s7b_pkg::DATA_W'(wt_outer);
      end
      s7b_pkg::REG_WEIGHT_FAR: begin
        wt_far = raw[s7b_pkg::WT_W-1:0];
        held = s7b_pkg::DATA_W'(wt_far);
      end
      s7b_pkg::REG_WEIGHT_NEAR: begin
        wt_near = raw[s7b_pkg::WT_W-1:0];
        held = s7b_pkg::DATA_W'(wt_near);
      end
      s7b_pkg::REG_WEIGHT_CENTER: begin
        wt_center = raw[s7b_pkg::WT_W-1:0];
        held = s7b_pkg::DATA_W'(wt_center);
      end
      default: held = '0;
    endcase
    reg_check(idx, held);
  endtask

  function automatic logic [s7b_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return 32'h8080_8080;
      3: return 32'h7F7F_7F7F;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [s7b_pkg::DATA_W-1:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return s7b_pkg::DATA_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [s7b_pkg::DATA_W-1:0] rand_dim();
    if ($urandom_range(0, 5) == 0) begin
      return s7b_pkg::DATA_W'($urandom_range(0, s7b_pkg::MIN_DIM - 1));
    end
    return s7b_pkg::DATA_W'($urandom_range(s7b_pkg::MIN_DIM, 9));
  endfunction

  function automatic void push_beat(input logic req,
                                    input logic [s7b_pkg::PIX_W-1:0] pix);
    s7b_pkg::pix_beat_t b;
    b.req_type = req;
    b.pixel_in = pix;
    pix_q.push_back(b);
  endfunction

  // one frame plus its flush tail; stray flushes inside and stray pixels in the tail
  function automatic int queue_frame();
    int n_pix;
    int n_flush;
    n_pix   = cfg_width * cfg_height;
    n_flush = s7b_pkg::HALF_TAPS * cfg_width + s7b_pkg::HALF_TAPS;
    for (int i = 0; i < n_pix; i++) begin
      push_beat($urandom_range(0, 24) == 0, rand_pixel());
    end
    for (int i = 0; i < n_flush; i++) begin
      push_beat($urandom_range(0, 9) != 0, rand_pixel());
    end
    return n_pix + n_flush;
  endfunction

  // 4x4 frame of corner values
  function automatic void queue_corner_frame();
    logic [s7b_pkg::PIX_W-1:0] pat [16];
    pat = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h8080_8080, 32'h7F7F_7F7F, 32'h0101_0101, 32'hFEFE_FEFE,
            32'hFF00_0000, 32'h00FF_0000, 32'hFFFF_FFFF, 32'h0000_00FF,
            32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    for (int i = 0; i < 16; i++) begin
      push_beat(i == 10, pat[i]);
    end
    for (int i = 0; i < 15; i++) begin
      push_beat(i != 7, i == 7 ? 32'hA5A5_A5A5 : 32'hFFFF_FFFF);
    end
  endfunction

  task automatic wait_idle();
    while (pix_q.size() > 0 || pix_valid || blurred_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int sent;
    int nframes;
    for (int i = 0; i < RING_SIZE; i++) begin
      hrow_ring[i] = '0;
    end
    for (int k = 0; k < s7b_pkg::TAPS; k++) begin
      tap_win[k] = '0;
    end
    col_cnt  = 0;
    row_cnt  = 0;
    warm_cnt = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    reg_check(s7b_pkg::REG_FRAME_WIDTH, s7b_pkg::DATA_W'(s7b_pkg::WIDTH_RESET));
    reg_check(s7b_pkg::REG_FRAME_HEIGHT, s7b_pkg::DATA_W'(s7b_pkg::HEIGHT_RESET));
    reg_check(s7b_pkg::REG_WEIGHT_OUTER, s7b_pkg::DATA_W'(s7b_pkg::OUTER_RESET));
    reg_check(s7b_pkg::REG_WEIGHT_FAR, s7b_pkg::DATA_W'(s7b_pkg::FAR_RESET));
    reg_check(s7b_pkg::REG_WEIGHT_NEAR, s7b_pkg::DATA_W'(s7b_pkg::NEAR_RESET));
    reg_check(s7b_pkg::REG_WEIGHT_CENTER, s7b_pkg::DATA_W'(s7b_pkg::CENTER_RESET));

    set_reg(s7b_pkg::REG_FRAME_WIDTH, '0);
    set_reg(s7b_pkg::REG_FRAME_HEIGHT, s7b_pkg::DATA_W'(3));
    set_reg(s7b_pkg::REG_WEIGHT_OUTER, 32'hFFFF_FFFF);
    set_reg(s7b_pkg::REG_WEIGHT_FAR, 32'hFFFF_FFFF);
    set_reg(s7b_pkg::REG_WEIGHT_NEAR, 32'hFFFF_FFFF);
    set_reg(s7b_pkg::REG_WEIGHT_CENTER, 32'hFFFF_FFFF);
    queue_corner_frame();
    wait_idle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_LIMIT;
      set_reg(s7b_pkg::REG_FRAME_WIDTH, rand_dim());
      set_reg(s7b_pkg::REG_FRAME_HEIGHT, rand_dim());
      set_reg(s7b_pkg::REG_WEIGHT_OUTER, rand_weight());
      set_reg(s7b_pkg::REG_WEIGHT_FAR, rand_weight());
      set_reg(s7b_pkg::REG_WEIGHT_NEAR, rand_weight());
      set_reg(s7b_pkg::REG_WEIGHT_CENTER, rand_weight());
      nframes = $urandom_range(1, 2);
      repeat (nframes) sent += queue_frame();
      wait_idle();
    end

    // clamp at the top of both dimensions
    set_reg(s7b_pkg::REG_FRAME_WIDTH, 32'hFFFF_FFFF);
    set_reg(s7b_pkg::REG_FRAME_HEIGHT, 32'hFFFF_FFFF);

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
